[rtl/core/frx_pkg.sv]
// ----------------------------------------------------------------------------
// frx_pkg
// Shared types, codes and constants for the framed packet receiver: parse
// phases, status codes, result and configuration bundles, length saturation.
// ----------------------------------------------------------------------------
package frx_pkg;

    // Largest payload length that a frame may carry
    localparam logic [15:0] MAX_PAYLOAD = 16'd128;

    // Header sync byte and checksum modulus
    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [8:0] SUM_MODULUS = 9'd255;

    // Register indexes on the configuration port
    localparam logic REG_OWN_ID  = 1'b0;
    localparam logic REG_PEER_ID = 1'b1;

    // Parse phases, one-hot
    typedef enum logic [7:0] {
        PH_FF_A     = 8'b0000_0001,
        PH_FF_B     = 8'b0000_0010,
        PH_SENDER   = 8'b0000_0100,
        PH_RECEIVER = 8'b0000_1000,
        PH_LEN_H    = 8'b0001_0000,
        PH_LEN_L    = 8'b0010_0000,
        PH_PAYLOAD  = 8'b0100_0000,
        PH_CHECK    = 8'b1000_0000
    } phase_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_NONE         = 3'd0,
        ST_PAYLOAD      = 3'd1,
        ST_GOOD         = 3'd2,
        ST_BAD_SUM      = 3'd3,
        ST_BAD_SENDER   = 3'd4,
        ST_BAD_RECEIVER = 3'd5,
        ST_TOO_LONG     = 3'd6
    } status_t;

    // One result word
    typedef struct packed {
        status_t    status;
        logic [7:0] payload_byte;
        logic [6:0] payload_index;
        logic [7:0] frame_length;
    } result_t;

    // Node ids from the configuration registers
    typedef struct packed {
        logic [7:0] own_id;
        logic [7:0] peer_id;
    } ids_t;

    // Saturate a 16-bit length to 8 bits
    function automatic logic [7:0] len_sat(input logic [15:0] len);
        return (|len[15:8]) ? 8'hFF : len[7:0];
    endfunction

endpackage

[rtl/core/frx_cfg.sv]
// ----------------------------------------------------------------------------
// frx_cfg
// APB-style register file holding this node's id and the partner id.
// ----------------------------------------------------------------------------
module frx_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output frx_pkg::ids_t    ids
);
    import frx_pkg::*;

    logic [7:0] own_id_reg;
    logic [7:0] peer_id_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Write the addressed id register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg  <= '0;
            peer_id_reg <= '0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_OWN_ID)
            begin
                own_id_reg <= pwdata[7:0];
            end
            if (paddr[2] == REG_PEER_ID)
            begin
                peer_id_reg <= pwdata[7:0];
            end
        end
    end

    // Read back the addressed register
    always_comb
    begin
        if (paddr[2] == REG_OWN_ID)
        begin
            prdata = {24'd0, own_id_reg};
        end
        else
        begin
            prdata = {24'd0, peer_id_reg};
        end
    end

    assign ids.own_id  = own_id_reg;
    assign ids.peer_id = peer_id_reg;

endmodule

[rtl/core/frx_parse.sv]
// ----------------------------------------------------------------------------
// frx_parse
// Frame parser: holds the parse phase, running checksum, length and payload
// count, and works out one result word for each accepted byte.
// ----------------------------------------------------------------------------
module frx_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  frx_pkg::ids_t     ids,
    output frx_pkg::result_t  result
);
    import frx_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  sum_reg,    sum_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  taken_reg,  taken_next;

    logic [8:0]  sum_add;
    logic [7:0]  sum_mod;
    logic [7:0]  taken_inc;
    logic [15:0] len_low;

    // Running checksum modulo 255: one conditional subtract
    assign sum_add   = {1'b0, sum_reg} + {1'b0, rx_byte};
    assign sum_mod   = (sum_add >= SUM_MODULUS) ? 8'(sum_add - SUM_MODULUS) : sum_add[7:0];
    assign taken_inc = taken_reg + 8'd1;
    assign len_low   = {length_reg[15:8], rx_byte};

    // Advance the parser on one byte
    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        length_next = length_reg;
        taken_next  = taken_reg;
        result      = '{status: ST_NONE, payload_byte: '0, payload_index: '0,
                        frame_length: '0};

        unique case (phase_reg)
            PH_FF_A:
            begin
                if (rx_byte == SYNC_BYTE)
                begin
                    // FF folds to zero in the mod-255 sum
                    sum_next    = '0;
                    length_next = '0;
                    taken_next  = '0;
                    phase_next  = PH_FF_B;
                end
            end
            PH_FF_B:
            begin
                if (rx_byte == SYNC_BYTE)
                begin
                    sum_next   = sum_mod;
                    phase_next = PH_SENDER;
                end
                else
                begin
                    phase_next = PH_FF_A;
                end
            end
            PH_SENDER:
            begin
                if (rx_byte == ids.peer_id)
                begin
                    sum_next   = sum_mod;
                    phase_next = PH_RECEIVER;
                end
                else
                begin
                    result.status = ST_BAD_SENDER;
                    phase_next    = PH_FF_A;
                end
            end
            PH_RECEIVER:
            begin
                if (rx_byte == ids.own_id)
                begin
                    sum_next   = sum_mod;
                    phase_next = PH_LEN_H;
                end
                else
                begin
                    result.status = ST_BAD_RECEIVER;
                    phase_next    = PH_FF_A;
                end
            end
            PH_LEN_H:
            begin
                sum_next    = sum_mod;
                length_next = {rx_byte, 8'd0};
                phase_next  = PH_LEN_L;
            end
            PH_LEN_L:
            begin
                sum_next    = sum_mod;
                length_next = len_low;
                if (len_low > MAX_PAYLOAD)
                begin
                    result.status       = ST_TOO_LONG;
                    result.frame_length = len_sat(len_low);
                    phase_next          = PH_FF_A;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                // A zero length still takes one byte
                sum_next             = sum_mod;
                result.status        = ST_PAYLOAD;
                result.payload_byte  = rx_byte;
                result.payload_index = taken_reg[6:0];
                result.frame_length  = len_sat(length_reg);
                taken_next           = taken_inc;
                if ({8'd0, taken_inc} >= length_reg)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                result.frame_length = len_sat(length_reg);
                result.status       = (rx_byte == sum_reg) ? ST_GOOD : ST_BAD_SUM;
                sum_next            = '0;
                phase_next          = PH_FF_A;
            end
            default:
            begin
                phase_next = PH_FF_A;
            end
        endcase
    end

    // Hold parser state, update on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FF_A;
            sum_reg    <= '0;
            length_reg <= '0;
            taken_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            length_reg <= length_next;
            taken_reg  <= taken_next;
        end
    end

endmodule

[rtl/core/frx_out.sv]
// ----------------------------------------------------------------------------
// frx_out
// Result register: holds one result word until the consumer takes it and
// stalls the input side only while a held word is itself stalled.
// ----------------------------------------------------------------------------
module frx_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  frx_pkg::result_t  result,
    output logic              out_valid,
    input  logic              out_stall,
    output frx_pkg::result_t  out_word
);
    import frx_pkg::*;

    logic    valid_reg, valid_next;
    result_t word_reg;
    logic    load;

    assign in_stall   = valid_reg & out_stall;
    assign load       = in_valid & ~in_stall;
    assign valid_next = load | (valid_reg & out_stall);

    // Track whether a word is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result word on accept
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

[rtl/core/framed_packet_receiver.sv]
// Output: a result word appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the input stalls only while a held result
// word is stalled by the consumer.
// Reset: rst_n clears the parser to hunting for the first FF, the checksum,
// length and count to zero, both id registers to zero, and the output empty.
// ----------------------------------------------------------------------------
// framed_packet_receiver
// Byte-serial deframer for FF FF, sender, receiver, 16-bit length, payload,
// mod-255 checksum frames, with an APB-style port for the node ids.
// ----------------------------------------------------------------------------
module framed_packet_receiver (
    input  logic        clk,
    input  logic        rst_n,
    // input byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  payload_byte,
    output logic [6:0]  payload_index,
    output logic [7:0]  frame_length,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import frx_pkg::*;

    ids_t    ids;
    result_t result;
    result_t out_word;
    logic    accept;

    assign accept = in_valid & ~in_stall;

    frx_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ids     (ids)
    );

    frx_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .ids     (ids),
        .result  (result)
    );

    frx_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .result    (result),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // Unpack the result word onto the field ports
    assign status        = out_word.status;
    assign payload_byte  = out_word.payload_byte;
    assign payload_index = out_word.payload_index;
    assign frame_length  = out_word.frame_length;

endmodule

[tb/tb_framed_packet_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_packet_receiver
// Self-checking bench for the framed packet receiver. A directed table covers
// the header, id and length error paths and a zero-length frame. Random
// frames follow under several id settings, with random idle cycles on both
// channels and one long output hold-off. Every result word is compared
// against its typed expectation or an in-bench model of the parser.
// ----------------------------------------------------------------------------
module tb_framed_packet_receiver;
    import frx_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_DIRECTED  = 24;
    localparam int NUM_SETTINGS  = 5;

    // One row of the directed table: byte to send, and a typed expectation
    // where the answer is obvious (otherwise the model decides)
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        status_t    st;
        logic [7:0] flen;
    } stim_row_t;

    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        // noise while hunting, then a broken second sync byte
        '{8'h00, 1'b1, ST_NONE,         8'h00},
        '{8'hFF, 1'b1, ST_NONE,         8'h00},
        '{8'h7E, 1'b1, ST_NONE,         8'h00},
        // wrong sender
        '{8'hFF, 1'b1, ST_NONE,         8'h00},
        '{8'hFF, 1'b1, ST_NONE,         8'h00},
        '{8'h01, 1'b1, ST_BAD_SENDER,   8'h00},
        // wrong receiver
        '{8'hFF, 1'b1, ST_NONE,         8'h00},
        '{8'hFF, 1'b1, ST_NONE,         8'h00},
        '{8'h00, 1'b1, ST_NONE,         8'h00},
        '{8'h05, 1'b1, ST_BAD_RECEIVER, 8'h00},
        // length 256 is too long, length reads saturated
        '{8'hFF, 1'b1, ST_NONE,         8'h00},
        '{8'hFF, 1'b1, ST_NONE,         8'h00},
        '{8'h00, 1'b1, ST_NONE,         8'h00},
        '{8'h00, 1'b1, ST_NONE,         8'h00},
        '{8'h01, 1'b1, ST_NONE,         8'h00},
        '{8'h00, 1'b1, ST_TOO_LONG,     8'hFF},
        // zero-length frame still carries one payload byte
        '{8'hFF, 1'b1, ST_NONE,         8'h00},
        '{8'hFF, 1'b1, ST_NONE,         8'h00},
        '{8'h00, 1'b1, ST_NONE,         8'h00},
        '{8'h00, 1'b1, ST_NONE,         8'h00},
        '{8'h00, 1'b1, ST_NONE,         8'h00},
        '{8'h00, 1'b1, ST_NONE,         8'h00},
        '{8'hAB, 1'b0, ST_NONE,         8'h00},
        '{8'hAB, 1'b0, ST_NONE,         8'h00}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic [6:0]  payload_index;
    logic [7:0]  frame_length;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    framed_packet_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_length  (frame_length),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Parser model state and its copy of the id registers
    phase_t      pr_phase = PH_FF_A;
    logic [7:0]  pr_sum = 8'd0;
    logic [15:0] pr_len = 16'd0;
    logic [7:0]  pr_taken = 8'd0;
    logic [7:0]  model_own_id = 8'd0;
    logic [7:0]  model_peer_id = 8'd0;

    result_t     pending_results[$];
    logic [7:0]  frame_buf[$];
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          status_count[8] = '{default: 0};
    int          send_mode = 0;
    int          recv_mode = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          cycle_count = 0;

    function automatic logic [7:0] mod255_add(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, b};
        if (s >= SUM_MODULUS)
            s = s - SUM_MODULUS;
        return s[7:0];
    endfunction

    function automatic logic [7:0] clamp_length(input logic [15:0] len);
        return (len > 16'd255) ? 8'hFF : len[7:0];
    endfunction

    // Advance the parser model by one byte and return the result word it owes
    function automatic result_t predict_frame_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        r.status = ST_NONE;
        case (pr_phase)
            PH_FF_A:
            begin
                if (b == SYNC_BYTE)
                begin
                    pr_len = 16'd0;
                    pr_taken = 8'd0;
                    pr_sum = mod255_add(8'd0, b);
                    pr_phase = PH_FF_B;
                end
            end
            PH_FF_B:
            begin
                if (b == SYNC_BYTE)
                begin
                    pr_sum = mod255_add(pr_sum, b);
                    pr_phase = PH_SENDER;
                end
                else
                    pr_phase = PH_FF_A;
            end
            PH_SENDER:
            begin
                if (b == model_peer_id)
                begin
                    pr_sum = mod255_add(pr_sum, b);
                    pr_phase = PH_RECEIVER;
                end
                else
                begin
                    r.status = ST_BAD_SENDER;
                    pr_phase = PH_FF_A;
                end
            end
            PH_RECEIVER:
            begin
                if (b == model_own_id)
                begin
                    pr_sum = mod255_add(pr_sum, b);
                    pr_phase = PH_LEN_H;
                end
                else
                begin
                    r.status = ST_BAD_RECEIVER;
                    pr_phase = PH_FF_A;
                end
            end
            PH_LEN_H:
            begin
                pr_sum = mod255_add(pr_sum, b);
                pr_len = {b, 8'h00};
                pr_phase = PH_LEN_L;
            end
            PH_LEN_L:
            begin
                pr_sum = mod255_add(pr_sum, b);
                pr_len = {pr_len[15:8], b};
                if (pr_len > MAX_PAYLOAD)
                begin
                    r.status = ST_TOO_LONG;
                    r.frame_length = clamp_length(pr_len);
                    pr_phase = PH_FF_A;
                end
                else
                    pr_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                pr_sum = mod255_add(pr_sum, b);
                r.status = ST_PAYLOAD;
                r.payload_byte = b;
                r.payload_index = pr_taken[6:0];
                r.frame_length = clamp_length(pr_len);
                pr_taken = pr_taken + 8'd1;
                if ({8'h00, pr_taken} >= pr_len)
                    pr_phase = PH_CHECK;
            end
            default:
            begin
                r.frame_length = clamp_length(pr_len);
                r.status = (b == pr_sum) ? ST_GOOD : ST_BAD_SUM;
                pr_sum = 8'd0;
                pr_phase = PH_FF_A;
            end
        endcase
        return r;
    endfunction

    // Idle cycles before the next word: none, occasional, or frequent
    function automatic int draw_wait(input int mode);
        if (mode == 0)
            return 0;
        if (mode == 1 && $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Offer one byte, hold it until taken, then queue the result it causes
    task automatic send_byte(input logic [7:0] b, input logic typed, input result_t typed_res);
        int gap;
        result_t r;
        gap = draw_wait(send_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        r = predict_frame_byte(b);
        pending_results.push_back(typed ? typed_res : r);
        bytes_sent++;
    endtask

    // Write an id register, then read it back
    task automatic write_id(input logic reg_idx, input logic [7:0] value);
        logic [31:0] noise;
        noise = $urandom();
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {noise[31:8], value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_idx == REG_OWN_ID)
            model_own_id = value;
        else
            model_peer_id = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[7:0] !== value)
        begin
            $error("prdata mismatch: expected %0h, actual %0h", value, prdata[7:0]);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Build one random frame into frame_buf: mostly well formed, with
    // checksum, id, length, truncation, sync and noise faults mixed in
    task automatic build_frame();
        int kind;
        int n;
        int pick;
        logic [7:0] sum;
        logic [7:0] snd;
        logic [7:0] rcv;
        logic [15:0] len;
        frame_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 94)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                frame_buf.push_back(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom()));
            return;
        end
        if (kind >= 89)
        begin
            frame_buf.push_back(SYNC_BYTE);
            frame_buf.push_back(8'($urandom_range(0, 254)));
            return;
        end
        snd = model_peer_id;
        rcv = model_own_id;
        if (kind >= 68 && kind < 73)
            snd = model_peer_id ^ 8'($urandom_range(1, 255));
        if (kind >= 73 && kind < 78)
            rcv = model_own_id ^ 8'($urandom_range(1, 255));
        pick = $urandom_range(0, 99);
        if (kind >= 78 && kind < 84)
        begin
            case ($urandom_range(0, 3))
                0: len = MAX_PAYLOAD + 16'd1;
                1: len = 16'd255;
                2: len = 16'($urandom_range(256, 65535));
                default: len = 16'hFFFF;
            endcase
        end
        else if (pick < 60)
            len = 16'($urandom_range(0, 8));
        else if (pick < 90)
            len = 16'($urandom_range(9, 40));
        else if (pick < 97)
            len = 16'($urandom_range(41, 127));
        else
            len = MAX_PAYLOAD;
        frame_buf = '{SYNC_BYTE, SYNC_BYTE, snd, rcv, len[15:8], len[7:0]};
        if (kind >= 68 && kind < 84)
            return;
        sum = 8'd0;
        foreach (frame_buf[i])
            sum = mod255_add(sum, frame_buf[i]);
        n = (len == 16'd0) ? 1 : int'(len);
        repeat (n)
        begin
            frame_buf.push_back(8'($urandom()));
            sum = mod255_add(sum, frame_buf[$]);
        end
        if (kind >= 60 && kind < 68)
            sum = sum ^ 8'($urandom_range(1, 255));
        frame_buf.push_back(sum);
        // drop the tail so the next frame lands mid-parse
        if (kind >= 84)
        begin
            n = $urandom_range(1, frame_buf.size() - 1);
            repeat (n) void'(frame_buf.pop_back());
        end
    endtask

    // Send random frames until the phase has its share of bytes
    task automatic send_frames(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            build_frame();
            send_mode = (hold_req || hold_left > 0) ? 0 : $urandom_range(0, 2);
            recv_mode = $urandom_range(0, 2);
            foreach (frame_buf[i])
                send_byte(frame_buf[i], 1'b0, '0);
        end
    endtask

    // Stop offering and wait until every result word has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0 || hold_left > 0);
    endtask

    // Compare one accepted result word with the oldest expectation
    task automatic check_result();
        result_t e;
        if (pending_results.size() == 0)
        begin
            $error("result word with no expectation: status %0d", status);
            fail_count++;
            return;
        end
        e = pending_results.pop_front();
        status_count[status]++;
        if (status !== e.status)
        begin
            $error("status mismatch: expected %0d, actual %0d", e.status, status);
            fail_count++;
        end
        if (payload_byte !== e.payload_byte)
        begin
            $error("payload_byte mismatch: expected %0h, actual %0h",
                   e.payload_byte, payload_byte);
            fail_count++;
        end
        if (payload_index !== e.payload_index)
        begin
            $error("payload_index mismatch: expected %0d, actual %0d",
                   e.payload_index, payload_index);
            fail_count++;
        end
        if (frame_length !== e.frame_length)
        begin
            $error("frame_length mismatch: expected %0d, actual %0d",
                   e.frame_length, frame_length);
            fail_count++;
        end
    endtask

    // Result side: check each word, then stall at random or for a long hold
    initial
    begin
        int w;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                check_result();
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                stall_left = 0;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                if (hold_left == 0)
                    out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    out_stall <= 1'b0;
            end
            else if (out_valid && !out_stall)
            begin
                w = draw_wait(recv_mode);
                if (w > 0)
                begin
                    stall_left = w;
                    out_stall <= 1'b1;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [7:0] own_set[NUM_SETTINGS];
        logic [7:0] peer_set[NUM_SETTINGS];
        own_set  = '{8'h00, 8'hFF, 8'hFF, 8'($urandom()), 8'($urandom())};
        peer_set = '{8'hFF, 8'h00, 8'hFF, 8'($urandom()), 8'($urandom())};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table with the reset ids
        send_mode = 1;
        recv_mode = 1;
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].rx, DIRECTED[i].typed,
                      {DIRECTED[i].st, 8'h00, 7'h00, DIRECTED[i].flen});
        drain();

        // Random frames under each id setting; hold the output in one of them
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            write_id(REG_OWN_ID, own_set[s]);
            write_id(REG_PEER_ID, peer_set[s]);
            if (s == 3)
                hold_req = 1'b1;
            send_frames(PHASE_BYTES);
            drain();
        end

        repeat (4) @(posedge clk);
        $display("Sent %0d bytes over %0d id settings, including a %0d-cycle output hold",
                 bytes_sent, NUM_SETTINGS + 1, HOLD_CYCLES);
        $display("Seen: %0d payload, %0d good, %0d bad sum, %0d id errors, %0d too long",
                 status_count[ST_PAYLOAD], status_count[ST_GOOD], status_count[ST_BAD_SUM],
                 status_count[ST_BAD_SENDER] + status_count[ST_BAD_RECEIVER],
                 status_count[ST_TOO_LONG]);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[framed_packet_receiver.f]
rtl/core/frx_pkg.sv
rtl/core/frx_cfg.sv
rtl/core/frx_parse.sv
rtl/core/frx_out.sv
rtl/core/framed_packet_receiver.sv
tb/tb_framed_packet_receiver.sv
